@@ rtl/core/igfr_pkg.sv @@
// igfr_pkg: shared types and constants for the idle gap frame receiver
// no dependencies; used by idle_gap_frame_receiver
`timescale 1ns / 1ps

package igfr_pkg;

    localparam int unsigned DEPTH_DEF    = 64;
    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned POS_W        = 6;
    localparam int unsigned LEN_W        = 7;
    localparam int unsigned LIMIT_W      = 8;
    localparam int unsigned APB_DATA_W   = 32;
    localparam int unsigned APB_ADDR_W   = 1;

    localparam logic [LIMIT_W-1:0]    LIMIT_RESET    = 8'd5;
    localparam logic [LIMIT_W-1:0]    IDLE_MAX       = 8'd255;
    localparam logic [APB_ADDR_W-1:0] REG_IDLE_LIMIT = 1'b0;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic {
        S_COLLECT,
        S_READOUT
    } t_state;

endpackage

@@ rtl/core/idle_gap_frame_receiver.sv @@
// idle_gap_frame_receiver: buffers received bytes and emits the frame after an idle gap
// depends on igfr_pkg
//
//  channel   handshake                  payload
//  input     i_in_valid / o_in_ready    i_opcode, i_rx_byte
//  output    o_out_valid / i_out_ready  o_frame_byte, o_byte_position, o_frame_length,
//                                       o_last_of_frame
//  config    psel, penable, pwrite      paddr, pwdata, prdata (pready tied high)
//
// bytes and ticks are taken while collecting; bytes go into frame memory while it has room
// a closing tick starts readout: one word per cycle via the memory read port while the
// output accepts; input is closed until the last word moves into the output register
// the output register lets the last word wait while the next input word is taken
// reset (synchronous, active low) clears counts and pending mark, loads limit 5; memory kept
`timescale 1ns / 1ps

module idle_gap_frame_receiver #(
    parameter int unsigned DEPTH = igfr_pkg::DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_opcode,
    input  logic [igfr_pkg::BYTE_W-1:0]         i_rx_byte,

    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [igfr_pkg::BYTE_W-1:0]         o_frame_byte,
    output logic [igfr_pkg::POS_W-1:0]          o_byte_position,
    output logic [igfr_pkg::LEN_W-1:0]          o_frame_length,
    output logic                                o_last_of_frame,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [igfr_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [igfr_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [igfr_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic [igfr_pkg::BYTE_W-1:0] r_mem [DEPTH];
    logic [igfr_pkg::BYTE_W-1:0] r_mem_q;

    igfr_pkg::t_state               r_state, n_state;
    logic [CW-1:0]                  r_count, n_count;
    logic                           r_pending, n_pending;
    logic [igfr_pkg::LIMIT_W-1:0]   r_idle, n_idle;
    logic [igfr_pkg::LIMIT_W-1:0]   r_limit;
    logic [CW-1:0]                  r_rd_idx, n_rd_idx;
    logic [CW-1:0]                  r_rd_pos, n_rd_pos;
    logic                           r_rd_vld, n_rd_vld;
    logic                           r_out_vld, n_out_vld;

    logic [igfr_pkg::BYTE_W-1:0]    r_out_byte;
    logic [igfr_pkg::POS_W-1:0]     r_out_pos;
    logic [igfr_pkg::LEN_W-1:0]     r_out_len;
    logic                           r_out_last;

    logic                           in_acc;
    logic                           mem_wr;
    logic                           rd_issue;
    logic                           out_load;
    logic [igfr_pkg::LIMIT_W-1:0]   idle_inc;
    logic [CW+igfr_pkg::LEN_W-1:0]  pos_ext;
    logic [CW+igfr_pkg::LEN_W-1:0]  len_ext;
    logic                           cfg_wr;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == igfr_pkg::REG_IDLE_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= igfr_pkg::LIMIT_RESET;
        end else if (cfg_wr) begin
            r_limit <= pwdata[igfr_pkg::LIMIT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == igfr_pkg::REG_IDLE_LIMIT) begin
            prdata[igfr_pkg::LIMIT_W-1:0] = r_limit;
        end
    end

    // control
    assign o_in_ready = (r_state == igfr_pkg::S_COLLECT);
    assign in_acc     = i_in_valid && o_in_ready;
    assign mem_wr     = in_acc && (i_opcode == igfr_pkg::OP_BYTE) && (r_count < DEPTH_C);
    assign out_load   = r_rd_vld && (!r_out_vld || i_out_ready);
    assign rd_issue   = (r_state == igfr_pkg::S_READOUT) && (r_rd_idx != r_count)
                        && (!r_rd_vld || out_load);
    assign idle_inc   = (r_idle == igfr_pkg::IDLE_MAX) ? r_idle : r_idle + 1'b1;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_pending = r_pending;
        n_idle    = r_idle;
        n_rd_idx  = r_rd_idx;
        n_rd_pos  = r_rd_pos;
        n_rd_vld  = r_rd_vld;
        n_out_vld = r_out_vld;

        if (out_load) begin
            n_out_vld = 1'b1;
            n_rd_vld  = 1'b0;
        end else if (o_out_valid && i_out_ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            igfr_pkg::S_COLLECT: begin
                if (in_acc) begin
                    if (i_opcode == igfr_pkg::OP_BYTE) begin
                        if (mem_wr) begin
                            n_count = r_count + 1'b1;
                        end
                        n_pending = 1'b1;
                        n_idle    = '0;
                    end else if (r_pending) begin
                        n_idle = idle_inc;
                        if (idle_inc >= r_limit) begin
                            n_state   = igfr_pkg::S_READOUT;
                            n_pending = 1'b0;
                            n_idle    = '0;
                            n_rd_idx  = '0;
                        end
                    end
                end
            end
            igfr_pkg::S_READOUT: begin
                if (rd_issue) begin
                    n_rd_idx = r_rd_idx + 1'b1;
                    n_rd_pos = r_rd_idx;
                    n_rd_vld = 1'b1;
                end else if ((r_rd_idx == r_count) && (!r_rd_vld || out_load)) begin
                    n_state = igfr_pkg::S_COLLECT;
                    n_count = '0;
                end
            end
            default: begin
                n_state = igfr_pkg::S_COLLECT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= igfr_pkg::S_COLLECT;
            r_count   <= '0;
            r_pending <= 1'b0;
            r_idle    <= '0;
            r_rd_idx  <= '0;
            r_rd_pos  <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_pending <= n_pending;
            r_idle    <= n_idle;
            r_rd_idx  <= n_rd_idx;
            r_rd_pos  <= n_rd_pos;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // frame memory
    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            r_mem[r_count[AW-1:0]] <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_issue) begin
            r_mem_q <= r_mem[r_rd_idx[AW-1:0]];
        end
    end

    // output word register
    assign pos_ext = {{igfr_pkg::LEN_W{1'b0}}, r_rd_pos};
    assign len_ext = {{igfr_pkg::LEN_W{1'b0}}, r_count};

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_byte <= r_mem_q;
            r_out_pos  <= pos_ext[igfr_pkg::POS_W-1:0];
            r_out_len  <= len_ext[igfr_pkg::LEN_W-1:0];
            r_out_last <= (r_rd_pos == r_count - 1'b1);
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_frame_byte    = r_out_byte;
    assign o_byte_position = r_out_pos;
    assign o_frame_length  = r_out_len;
    assign o_last_of_frame = r_out_last;

endmodule
